/* hdl/gptm_pkg.sv */
package gptm_pkg;

  // view, map and cordic sizing
  localparam int MAX_VIEW_WIDTH = 1024;
  localparam int MAX_RADIUS     = MAX_VIEW_WIDTH / 2;
  localparam int MAX_MAP_DIM    = 4096;
  localparam int CORDIC_STEPS   = 16;

  // square root pipelines: two radicand bits per stage
  localparam int SQ1_STEPS = 19;
  localparam int SQ2_STEPS = 24;

  // total stages from input register to output register
  localparam int LAT = 13 + SQ1_STEPS + SQ2_STEPS + 2 * CORDIC_STEPS;

  // cordic datapath widths
  localparam int CW = 32;
  localparam int AW = 34;
  localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;

  // configuration register indexes
  localparam logic [2:0] REG_RADIUS  = 3'd0;
  localparam logic [2:0] REG_ROT_W   = 3'd1;
  localparam logic [2:0] REG_ROT_I   = 3'd2;
  localparam logic [2:0] REG_ROT_J   = 3'd3;
  localparam logic [2:0] REG_ROT_K   = 3'd4;
  localparam logic [2:0] REG_ROWS    = 3'd5;
  localparam logic [2:0] REG_COLUMNS = 3'd6;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic       on;
  } tag_t;

  typedef struct packed {
    logic        z;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
  } cordic_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic signed [AW-1:0] arc_angle(input int i);
    logic signed [AW-1:0] a;
    case (i)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10680862;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // quadrant pre-rotation when x is negative
  function automatic cordic_t cordic_pre(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
    cordic_t c;
    c.z = (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.ang = QUARTER_TURN;
      end else begin
        c.x = -y;
        c.y = x;
        c.ang = -QUARTER_TURN;
      end
    end else begin
      c.x = x;
      c.y = y;
      c.ang = '0;
    end
    return c;
  endfunction

  // one vectoring step
  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t n;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    n.z = c.z;
    if (c.y > 0) begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.ang = c.ang + arc_angle(i);
    end else begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.ang = c.ang - arc_angle(i);
    end
    return n;
  endfunction

  // both operands zero give angle zero
  function automatic logic signed [AW-1:0] cordic_angle(input cordic_t c);
    return c.z ? '0 : c.ang;
  endfunction

  // one digit of restoring square root
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [1:0] pair);
    sqrt_t n;
    logic [31:0] r2;
    logic [31:0] trial;
    r2 = {s.rem[29:0], pair};
    trial = {s.root[29:0], 2'b01};
    if (r2 >= trial) begin
      n.rem = r2 - trial;
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem = r2;
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  // map dimension limited to 1 .. MAX_MAP_DIM
  function automatic logic [12:0] clamp_dim(input logic [12:0] d);
    logic [12:0] r;
    if (d == '0) r = 13'd1;
    else if (d > 13'(MAX_MAP_DIM)) r = 13'(MAX_MAP_DIM);
    else r = d;
    return r;
  endfunction

  // index limited to 0 .. dim-1
  function automatic logic [11:0] clamp_index(input logic signed [17:0] v,
                                              input logic [12:0] dim);
    logic [12:0] top;
    logic [11:0] r;
    top = dim - 13'd1;
    if (v < 0) r = '0;
    else if (v >= $signed({5'b0, dim})) r = top[11:0];
    else r = v[11:0];
    return r;
  endfunction

endpackage

/* hdl/globe_pixel_texture_mapper_unit.sv */
// channel   | direction | signals
// s_axis    | in        | tvalid, tready, tdata = pixel_col, pixel_row
// m_axis    | out       | tvalid, tready, tdata = out_col, out_row, texel_col,
//           |           | texel_row; tuser = on_globe
// cfg       | in        | valid, ready, index, data (always ready)
//
// one pixel per clock while the output is not stalled; each item passes through
// the two digit-per-stage square root pipelines and two cordic chains
// reset is synchronous and restores the default registers and empties the pipe
// a stall at the output holds every stage in place; s_axis_tready follows it
module globe_pixel_texture_mapper_unit
  import gptm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pixel_col[9:0], pixel_row[19:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_col[9:0], out_row[19:10], texel_col[31:20], texel_row[43:32]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser,  // on_globe[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [9:0]         radius;
  logic signed [15:0] qw, qi, qj, qk;
  logic [12:0]        map_rows, map_columns;
  logic [LAT-1:0]     vpipe;
  logic               en;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 10'd256;
      qw          <= 16'sd16384;
      qi          <= '0;
      qj          <= '0;
      qk          <= '0;
      map_rows    <= 13'd2048;
      map_columns <= 13'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS:  radius      <= cfg_data[9:0];
        REG_ROT_W:   qw          <= cfg_data;
        REG_ROT_I:   qi          <= cfg_data;
        REG_ROT_J:   qj          <= cfg_data;
        REG_ROT_K:   qk          <= cfg_data;
        REG_ROWS:    map_rows    <= cfg_data[12:0];
        REG_COLUMNS: map_columns <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid chain
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vpipe[LAT-1];
  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (en) vpipe <= {vpipe[LAT-2:0], s_axis_tvalid};
  end

  // stage a: half pixel coordinates
  logic [9:0]         r_eff;
  tag_t               a_tag;
  logic signed [12:0] a_x0, a_y0;
  assign r_eff = (radius > 10'(MAX_RADIUS)) ? 10'(MAX_RADIUS) : radius;
  always_ff @(posedge clk) begin
    if (en) begin
      a_tag.col <= s_axis_tdata[9:0];
      a_tag.row <= s_axis_tdata[19:10];
      a_tag.on  <= 1'b0;
      a_x0 <= $signed({2'b00, s_axis_tdata[9:0], 1'b1} - {2'b00, r_eff, 1'b0});
      a_y0 <= $signed({2'b00, s_axis_tdata[19:10], 1'b1} - {2'b00, r_eff, 1'b0});
    end
  end

  // stage b: squares
  tag_t               b_tag;
  logic signed [12:0] b_x0, b_y0;
  logic signed [25:0] b_x2, b_y2;
  logic [21:0]        b_r4;
  always_ff @(posedge clk) begin
    if (en) begin
      b_tag <= a_tag;
      b_x0  <= a_x0;
      b_y0  <= a_y0;
      b_x2  <= 26'(a_x0) * 26'(a_x0);
      b_y2  <= 26'(a_y0) * 26'(a_y0);
      b_r4  <= 22'({r_eff, 1'b0}) * 22'({r_eff, 1'b0});
    end
  end

  // stage c: disc test, feeds the depth square root
  logic signed [26:0] c_d2;
  assign c_d2 = $signed({5'b0, b_r4}) - 27'(b_x2) - 27'(b_y2);

  logic [37:0]        s1_rad  [0:SQ1_STEPS];
  sqrt_t              s1_sq   [0:SQ1_STEPS];
  tag_t               s1_tag  [0:SQ1_STEPS];
  logic signed [20:0] s1_px   [0:SQ1_STEPS];
  logic signed [20:0] s1_py   [0:SQ1_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag[0].col <= b_tag.col;
      s1_tag[0].row <= b_tag.row;
      s1_tag[0].on  <= !c_d2[26];
      s1_rad[0] <= c_d2[26] ? '0 : {c_d2[21:0], 16'b0};
      s1_sq[0]  <= '0;
      s1_px[0]  <= {b_x0, 8'b0};
      s1_py[0]  <= {b_y0, 8'b0};
    end
  end

  // depth square root, one result bit per stage
  for (genvar k = 0; k < SQ1_STEPS; k++) begin : g_sq1
    sqrt_t nx;
    always_comb nx = sqrt_step(s1_sq[k], s1_rad[k][37:36]);
    always_ff @(posedge clk) begin
      if (en) begin
        s1_sq[k+1]  <= nx;
        s1_rad[k+1] <= {s1_rad[k][35:0], 2'b00};
        s1_tag[k+1] <= s1_tag[k];
        s1_px[k+1]  <= s1_px[k];
        s1_py[k+1]  <= s1_py[k];
      end
    end
  end

  // rotation stage 1: q * p products
  logic signed [20:0] px, py, pz;
  tag_t               r1_tag;
  logic signed [36:0] m_wx, m_wy, m_wz, m_ix, m_iy, m_iz;
  logic signed [36:0] m_jx, m_jy, m_jz, m_kx, m_ky, m_kz;
  assign px = s1_px[SQ1_STEPS];
  assign py = s1_py[SQ1_STEPS];
  assign pz = -$signed({2'b00, s1_sq[SQ1_STEPS].root[18:0]});
  always_ff @(posedge clk) begin
    if (en) begin
      r1_tag <= s1_tag[SQ1_STEPS];
      m_wx <= 37'(qw) * 37'(px);  m_wy <= 37'(qw) * 37'(py);  m_wz <= 37'(qw) * 37'(pz);
      m_ix <= 37'(qi) * 37'(px);  m_iy <= 37'(qi) * 37'(py);  m_iz <= 37'(qi) * 37'(pz);
      m_jx <= 37'(qj) * 37'(px);  m_jy <= 37'(qj) * 37'(py);  m_jz <= 37'(qj) * 37'(pz);
      m_kx <= 37'(qk) * 37'(px);  m_ky <= 37'(qk) * 37'(py);  m_kz <= 37'(qk) * 37'(pz);
    end
  end

  // rotation stage 2: t = q * p
  tag_t               r2_tag;
  logic signed [38:0] tw, ti, tj, tk;
  always_ff @(posedge clk) begin
    if (en) begin
      r2_tag <= r1_tag;
      tw <= -39'(m_ix) - 39'(m_jy) - 39'(m_kz);
      ti <= 39'(m_wx) + 39'(m_jz) - 39'(m_ky);
      tj <= 39'(m_wy) - 39'(m_iz) + 39'(m_kx);
      tk <= 39'(m_wz) + 39'(m_iy) - 39'(m_jx);
    end
  end

  // rotation stage 3: t * conj(q) products
  tag_t               r3_tag;
  logic signed [54:0] n_iw, n_wi, n_jk, n_kj, n_wj, n_ik;
  logic signed [54:0] n_jw, n_ki, n_wk, n_ij, n_ji, n_kw;
  always_ff @(posedge clk) begin
    if (en) begin
      r3_tag <= r2_tag;
      n_iw <= 55'(ti) * 55'(qw);  n_wi <= 55'(tw) * 55'(qi);
      n_jk <= 55'(tj) * 55'(qk);  n_kj <= 55'(tk) * 55'(qj);
      n_wj <= 55'(tw) * 55'(qj);  n_ik <= 55'(ti) * 55'(qk);
      n_jw <= 55'(tj) * 55'(qw);  n_ki <= 55'(tk) * 55'(qi);
      n_wk <= 55'(tw) * 55'(qk);  n_ij <= 55'(ti) * 55'(qj);
      n_ji <= 55'(tj) * 55'(qi);  n_kw <= 55'(tk) * 55'(qw);
    end
  end

  // rotation stage 4: sums rounded half up to 8 fraction bits
  localparam logic signed [57:0] RND28 = 58'sd134217728;
  logic signed [57:0] sx, sy, sz;
  assign sx = 58'(n_iw) - 58'(n_wi) - 58'(n_jk) + 58'(n_kj) + RND28;
  assign sy = -58'(n_wj) + 58'(n_ik) + 58'(n_jw) - 58'(n_ki) + RND28;
  assign sz = -58'(n_wk) - 58'(n_ij) + 58'(n_ji) + 58'(n_kw) + RND28;

  tag_t               r4_tag;
  logic signed [25:0] xr, yr, zr;
  always_ff @(posedge clk) begin
    if (en) begin
      r4_tag <= r3_tag;
      xr <= sx[53:28];
      yr <= sy[53:28];
      zr <= sz[53:28];
    end
  end

  // longitude cordic: atan2(x, -z)
  cordic_t            lc   [0:CORDIC_STEPS];
  tag_t               ltag [0:CORDIC_STEPS];
  logic signed [25:0] lxr  [0:CORDIC_STEPS];
  logic signed [25:0] lyr  [0:CORDIC_STEPS];
  logic signed [25:0] lzr  [0:CORDIC_STEPS];
  always_ff @(posedge clk) begin
    if (en) begin
      lc[0]   <= cordic_pre(-CW'(zr), CW'(xr));
      ltag[0] <= r4_tag;
      lxr[0]  <= xr;
      lyr[0]  <= yr;
      lzr[0]  <= zr;
    end
  end
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_lon
    cordic_t nx;
    always_comb nx = cordic_step(lc[k], k);
    always_ff @(posedge clk) begin
      if (en) begin
        lc[k+1]   <= nx;
        ltag[k+1] <= ltag[k];
        lxr[k+1]  <= lxr[k];
        lyr[k+1]  <= lyr[k];
        lzr[k+1]  <= lzr[k];
      end
    end
  end

  // horizontal radius squares
  tag_t                 h_tag;
  logic signed [AW-1:0] h_lon;
  logic signed [25:0]   h_yr;
  logic signed [51:0]   h_x2, h_z2;
  logic signed [52:0]   h_sum;
  always_ff @(posedge clk) begin
    if (en) begin
      h_tag <= ltag[CORDIC_STEPS];
      h_lon <= cordic_angle(lc[CORDIC_STEPS]);
      h_yr  <= lyr[CORDIC_STEPS];
      h_x2  <= 52'(lxr[CORDIC_STEPS]) * 52'(lxr[CORDIC_STEPS]);
      h_z2  <= 52'(lzr[CORDIC_STEPS]) * 52'(lzr[CORDIC_STEPS]);
    end
  end
  assign h_sum = 53'(h_x2) + 53'(h_z2);

  logic [47:0]          s2_rad [0:SQ2_STEPS];
  sqrt_t                s2_sq  [0:SQ2_STEPS];
  tag_t                 s2_tag [0:SQ2_STEPS];
  logic signed [AW-1:0] s2_lon [0:SQ2_STEPS];
  logic signed [25:0]   s2_yr  [0:SQ2_STEPS];
  always_ff @(posedge clk) begin
    if (en) begin
      s2_rad[0] <= h_sum[47:0];
      s2_sq[0]  <= '0;
      s2_tag[0] <= h_tag;
      s2_lon[0] <= h_lon;
      s2_yr[0]  <= h_yr;
    end
  end

  // horizontal radius square root
  for (genvar k = 0; k < SQ2_STEPS; k++) begin : g_sq2
    sqrt_t nx;
    always_comb nx = sqrt_step(s2_sq[k], s2_rad[k][47:46]);
    always_ff @(posedge clk) begin
      if (en) begin
        s2_sq[k+1]  <= nx;
        s2_rad[k+1] <= {s2_rad[k][45:0], 2'b00};
        s2_tag[k+1] <= s2_tag[k];
        s2_lon[k+1] <= s2_lon[k];
        s2_yr[k+1]  <= s2_yr[k];
      end
    end
  end

  // latitude cordic: atan2(-y, hyp)
  cordic_t              tc    [0:CORDIC_STEPS];
  tag_t                 ttag  [0:CORDIC_STEPS];
  logic signed [AW-1:0] tlon  [0:CORDIC_STEPS];
  always_ff @(posedge clk) begin
    if (en) begin
      tc[0]   <= cordic_pre($signed({8'b0, s2_sq[SQ2_STEPS].root[23:0]}),
                            -CW'(s2_yr[SQ2_STEPS]));
      ttag[0] <= s2_tag[SQ2_STEPS];
      tlon[0] <= s2_lon[SQ2_STEPS];
    end
  end
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_lat
    cordic_t nx;
    always_comb nx = cordic_step(tc[k], k);
    always_ff @(posedge clk) begin
      if (en) begin
        tc[k+1]   <= nx;
        ttag[k+1] <= ttag[k];
        tlon[k+1] <= tlon[k];
      end
    end
  end

  // scale angles by map dimensions
  logic [12:0]          rows_c, cols_c;
  logic signed [34:0]   lon_off, lat_off;
  tag_t                 m_tag;
  logic signed [48:0]   bxp, byp;
  assign rows_c  = clamp_dim(map_rows);
  assign cols_c  = clamp_dim(map_columns);
  assign lon_off = 35'(tlon[CORDIC_STEPS]) + 35'sd2147483648;
  assign lat_off = 35'sd1073741824 - 35'(cordic_angle(tc[CORDIC_STEPS]));
  always_ff @(posedge clk) begin
    if (en) begin
      m_tag <= ttag[CORDIC_STEPS];
      bxp   <= 49'(lon_off) * 49'($signed({1'b0, cols_c}));
      byp   <= 49'(lat_off) * 49'($signed({1'b0, rows_c}));
    end
  end

  // round, clamp and output register
  logic signed [48:0] bx_r, by_r;
  logic [11:0]        tex_col, tex_row;
  assign bx_r = bxp + 49'sd2147483648;
  assign by_r = byp + 49'sd1073741824;
  assign tex_col = clamp_index({bx_r[48], bx_r[48:32]}, cols_c);
  assign tex_row = clamp_index(by_r[48:31], rows_c);
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {4'b0, m_tag.on ? tex_row : 12'd0,
                       m_tag.on ? tex_col : 12'd0, m_tag.row, m_tag.col};
      m_axis_tuser <= m_tag.on;
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import gptm_pkg::*;

  // tab of arctangent steps, 2^32 per turn
  localparam longint ARC_TAB [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};
  localparam int STALL_LIMIT = 20000;
  // an index past the last register
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [9:0]  col;
    logic [9:0]  row;
    logic        on;
    logic [11:0] tx_col;
    logic [11:0] tx_row;
  } texel_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // pixel_col[9:0], pixel_row[19:10]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // out_col[9:0], out_row[19:10], texel_col[31:20], texel_row[43:32]
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;  // on_globe[0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // shadow copy of the registers
  logic [9:0]  sh_radius;
  logic [15:0] sh_w, sh_i, sh_j, sh_k;
  logic [12:0] sh_rows, sh_cols;

  texel_t texel_q[$];
  int     err_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     quiet_cycles;

  globe_pixel_texture_mapper_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor division by 2^n, exact for negatives
  function automatic longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint isqrt(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint ang, t, dx, dy;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = 64'sd1073741824;
      end else begin
        xv = -yv; yv = t; ang = -64'sd1073741824;
      end
    end
    for (int s = 0; s < CORDIC_STEPS; s++) begin
      dx = fshift(yv, s);
      dy = fshift(xv, s);
      if (yv > 0) begin
        xv += dx; yv -= dy; ang += ARC_TAB[s];
      end else begin
        xv -= dx; yv += dy; ang -= ARC_TAB[s];
      end
    end
    return ang;
  endfunction

  function automatic longint dim_of(logic [12:0] d);
    if (d == 0) return 1;
    if (d > MAX_MAP_DIM) return MAX_MAP_DIM;
    return longint'(d);
  endfunction

  function automatic longint idx_of(longint v, longint dim);
    if (v < 0) return 0;
    if (v >= dim) return dim - 1;
    return v;
  endfunction

  // texel lookup for one pixel under the current registers
  function automatic texel_t map_pixel(logic [9:0] col, logic [9:0] row);
    texel_t e;
    longint r, x0, y0, d2, px, py, pz, qw, qi, qj, qk, tw, ti, tj, tk;
    longint xr, yr, zr, lon, lat, rows, cols, hyp, bx, by;
    e.col = col; e.row = row; e.on = 1'b0; e.tx_col = '0; e.tx_row = '0;
    r = longint'(sh_radius);
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    x0 = 2 * (longint'(col) - r) + 1;
    y0 = 2 * (longint'(row) - r) + 1;
    d2 = 4 * r * r - x0 * x0 - y0 * y0;
    if (d2 < 0) return e;
    px = x0 * 256;
    py = y0 * 256;
    pz = -isqrt(d2 * 65536);
    qw = $signed(sh_w); qi = $signed(sh_i); qj = $signed(sh_j); qk = $signed(sh_k);
    tw = -qi * px - qj * py - qk * pz;
    ti = qw * px + qj * pz - qk * py;
    tj = qw * py - qi * pz + qk * px;
    tk = qw * pz + qi * py - qj * px;
    xr = fshift(ti * qw - tw * qi - tj * qk + tk * qj + (64'sd1 <<< 27), 28);
    yr = fshift(-tw * qj + ti * qk + tj * qw - tk * qi + (64'sd1 <<< 27), 28);
    zr = fshift(-tw * qk - ti * qj + tj * qi + tk * qw + (64'sd1 <<< 27), 28);
    lon = vector_angle(xr, -zr);
    hyp = isqrt(xr * xr + zr * zr);
    lat = vector_angle(-yr, hyp);
    rows = dim_of(sh_rows);
    cols = dim_of(sh_cols);
    bx = idx_of(fshift((lon + 64'sd2147483648) * cols + 64'sd2147483648, 32), cols);
    by = idx_of(fshift((64'sd1073741824 - lat) * rows + 64'sd1073741824, 31), rows);
    e.on = 1'b1;
    e.tx_col = 12'(bx);
    e.tx_row = 12'(by);
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_count++;
  endtask

  // result checker and output stall
  always @(posedge clk) begin
    texel_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (texel_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          e = texel_q.pop_front();
          if (m_axis_tdata[9:0] != e.col)
            report_mismatch("out_col", m_axis_tdata[9:0], e.col);
          if (m_axis_tdata[19:10] != e.row)
            report_mismatch("out_row", m_axis_tdata[19:10], e.row);
          if (m_axis_tuser != e.on)
            report_mismatch("on_globe", m_axis_tuser, e.on);
          if (m_axis_tdata[31:20] != e.tx_col)
            report_mismatch("texel_col", m_axis_tdata[31:20], e.tx_col);
          if (m_axis_tdata[43:32] != e.tx_row)
            report_mismatch("texel_row", m_axis_tdata[43:32], e.tx_row);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready) || texel_q.size() == 0) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // valid stays high across back to back items; drain drops it at the end
  task automatic send_pixel(logic [9:0] col, logic [9:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, row, col};
    texel_q.push_back(map_pixel(col, row));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RADIUS:  sh_radius = val[9:0];
      REG_ROT_W:   sh_w = val;
      REG_ROT_I:   sh_i = val;
      REG_ROT_J:   sh_j = val;
      REG_ROT_K:   sh_k = val;
      REG_ROWS:    sh_rows = val[12:0];
      REG_COLUMNS: sh_cols = val[12:0];
      default: ;
    endcase
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic set_rotation(logic [15:0] w, logic [15:0] i, logic [15:0] j,
                              logic [15:0] k);
    write_reg(REG_ROT_W, w);
    write_reg(REG_ROT_I, i);
    write_reg(REG_ROT_J, j);
    write_reg(REG_ROT_K, k);
  endtask

  function automatic logic [15:0] rand_q();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // random pixels, mostly inside the view square
  task automatic random_pixels(int n);
    int span;
    for (int c = 0; c < n; c++) begin
      span = 2 * (sh_radius > MAX_RADIUS ? MAX_RADIUS : sh_radius);
      if (span > 0 && $urandom_range(9) < 8)
        send_pixel(10'($urandom_range(span - 1)), 10'($urandom_range(span - 1)));
      else
        send_pixel(10'($urandom), 10'($urandom));
    end
  endtask

  task automatic test_directed_defaults();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd256, 10'd256);
    send_pixel(10'd255, 10'd255);
    send_pixel(10'd0, 10'd256);
    send_pixel(10'd511, 10'd256);
    send_pixel(10'd256, 10'd0);
    send_pixel(10'd256, 10'd511);
    send_pixel(10'd512, 10'd0);
    send_pixel(10'h2aa, 10'h155);
    send_pixel(10'h155, 10'h2aa);
    drain();
  endtask

  task automatic test_corner_registers();
    // radius zero, then above the maximum and one, with degenerate map sizes
    write_reg(REG_RADIUS, 16'd0);
    send_pixel(10'd0, 10'd0);
    drain();
    write_reg(REG_RADIUS, 16'd1023);
    write_reg(REG_ROWS, 16'd0);
    write_reg(REG_COLUMNS, 16'h1fff);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd511);
    send_pixel(10'd1023, 10'd1023);
    drain();
    write_reg(REG_RADIUS, 16'd1);
    write_reg(REG_ROWS, 16'd4096);
    write_reg(REG_COLUMNS, 16'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd1);
    send_pixel(10'd2, 10'd0);
    drain();
    // non-unit and negative quaternions, unknown register index
    write_reg(REG_RADIUS, 16'd512);
    set_rotation(16'h8000, 16'h7fff, 16'hc000, 16'h4000);
    write_reg(REG_UNUSED, 16'hffff);
    send_pixel(10'd100, 10'd900);
    send_pixel(10'd511, 10'd512);
    drain();
    set_rotation(16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(10'd512, 10'd512);
    drain();
  endtask

  task automatic test_random_phase(int idle, int stall, int n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_reg(REG_RADIUS, 16'($urandom_range(512, 1)));
    if ($urandom_range(3) == 0) set_rotation(rand_q(), rand_q(), rand_q(), rand_q());
    else set_rotation(16'd11585, 16'($urandom_range(1) ? 11585 : -11585), 16'd0, 16'd0);
    write_reg(REG_ROWS, 16'($urandom_range(4096, 1)));
    write_reg(REG_COLUMNS, 16'($urandom_range(4096, 1)));
    random_pixels(n);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sh_radius = 10'd256; sh_w = 16'd16384; sh_i = '0; sh_j = '0; sh_k = '0;
    sh_rows = 13'd2048; sh_cols = 13'd4096;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_defaults();
    test_corner_registers();
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: test_random_phase(0, 0, 190);
        1: test_random_phase(67, 0, 190);
        2: test_random_phase(0, 67, 190);
        default: test_random_phase(20, 20, 190);
      endcase
    end

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
